// ===== rtl/tbr_pkg.sv =====
// Shared types and constants for the triangle bounding-box rasterizer.
// Used by the register file, the setup and coverage logic and the top level.
package tbr_pkg;

   localparam int COORD_BITS_DEF = 12;
   localparam int DIM_W          = 12;
   localparam int COLOR_W        = 32;
   localparam int PIX_W          = 11;
   localparam int ADDR_W         = 4;
   localparam int DATA_W         = 32;
   localparam int REG_IDX_W      = 2;

   localparam logic OP_START   = 1'b0;
   localparam logic OP_ADVANCE = 1'b1;

   localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_PIXEL_COLOR  = 2'd2;

   localparam logic [DIM_W-1:0]   IMAGE_WIDTH_RST  = 12'd640;
   localparam logic [DIM_W-1:0]   IMAGE_HEIGHT_RST = 12'd480;
   localparam logic [COLOR_W-1:0] PIXEL_COLOR_RST  = '0;

   typedef struct packed {
      logic [DIM_W-1:0]   image_width;
      logic [DIM_W-1:0]   image_height;
      logic [COLOR_W-1:0] pixel_color;
   } csr_regs_type;

endpackage

// ===== rtl/tbr_csr.sv =====
// Configuration register file behind the APB-style port.
// Depends on tbr_pkg for register indexes, widths and reset values.
module tbr_csr
   import tbr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0] csr_pwdata,
   output logic [DATA_W-1:0] csr_prdata,
   output csr_regs_type      regs
);

   csr_regs_type           regs_ff;
   csr_regs_type           regs_in;
   logic [REG_IDX_W-1:0]   reg_idx;
   logic                   wr_en;

   assign reg_idx = csr_paddr[ADDR_W-1:2];
   assign wr_en   = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      regs_in = regs_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_IMAGE_WIDTH:  regs_in.image_width  = csr_pwdata[DIM_W-1:0];
            REG_IMAGE_HEIGHT: regs_in.image_height = csr_pwdata[DIM_W-1:0];
            REG_PIXEL_COLOR:  regs_in.pixel_color  = csr_pwdata[COLOR_W-1:0];
            default:          regs_in = regs_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.image_width  <= IMAGE_WIDTH_RST;
         regs_ff.image_height <= IMAGE_HEIGHT_RST;
         regs_ff.pixel_color  <= PIXEL_COLOR_RST;
      end else begin
         regs_ff <= regs_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_IMAGE_WIDTH:  csr_prdata = DATA_W'(regs_ff.image_width);
         REG_IMAGE_HEIGHT: csr_prdata = DATA_W'(regs_ff.image_height);
         REG_PIXEL_COLOR:  csr_prdata = DATA_W'(regs_ff.pixel_color);
         default:          csr_prdata = '0;
      endcase
   end

   assign regs = regs_ff;

endmodule

// ===== rtl/tbr_bbox.sv =====
// Bounding-box setup: min/max of the vertices, culling and clamping to the image.
// Depends on tbr_pkg for the image dimension width.
module tbr_bbox
   import tbr_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic signed [COORD_BITS-1:0] ax,
   input  logic signed [COORD_BITS-1:0] ay,
   input  logic signed [COORD_BITS-1:0] bx,
   input  logic signed [COORD_BITS-1:0] by,
   input  logic signed [COORD_BITS-1:0] cx,
   input  logic signed [COORD_BITS-1:0] cy,
   input  logic        [DIM_W-1:0]      image_width,
   input  logic        [DIM_W-1:0]      image_height,
   output logic        [COORD_BITS-1:0] left,
   output logic        [COORD_BITS-1:0] right,
   output logic        [COORD_BITS-1:0] bottom,
   output logic        [COORD_BITS-1:0] top,
   output logic                         box_active
);

   localparam int KW = ((COORD_BITS > DIM_W) ? COORD_BITS : DIM_W) + 2;

   logic signed [KW-1:0] ax_s, ay_s, bx_s, by_s, cx_s, cy_s;
   logic signed [KW-1:0] w_s, h_s;
   logic signed [KW-1:0] l_v, r_v, b_v, t_v;
   logic signed [KW-1:0] l_c, r_c, b_c, t_c;
   logic                 culled;

   assign ax_s = KW'(ax);
   assign ay_s = KW'(ay);
   assign bx_s = KW'(bx);
   assign by_s = KW'(by);
   assign cx_s = KW'(cx);
   assign cy_s = KW'(cy);
   assign w_s  = $signed(KW'(image_width));
   assign h_s  = $signed(KW'(image_height));

   always_comb begin
      l_v = ax_s;
      if (l_v > bx_s) l_v = bx_s;
      if (l_v > cx_s) l_v = cx_s;
      r_v = ax_s;
      if (r_v < bx_s) r_v = bx_s;
      if (r_v < cx_s) r_v = cx_s;
      b_v = ay_s;
      if (b_v > by_s) b_v = by_s;
      if (b_v > cy_s) b_v = cy_s;
      t_v = ay_s;
      if (t_v < by_s) t_v = by_s;
      if (t_v < cy_s) t_v = cy_s;

      culled = (l_v > w_s) || (r_v < 0) || (t_v < 0) || (b_v > h_s);

      l_c = (l_v < 0) ? '0 : l_v;
      r_c = (r_v > w_s) ? w_s : r_v;
      b_c = (b_v < 0) ? '0 : b_v;
      t_c = (t_v > h_s) ? h_s : t_v;
      if (culled) begin
         l_c = '0;
         r_c = '0;
         b_c = '0;
         t_c = '0;
      end
   end

   assign left       = l_c[COORD_BITS-1:0];
   assign right      = r_c[COORD_BITS-1:0];
   assign bottom     = b_c[COORD_BITS-1:0];
   assign top        = t_c[COORD_BITS-1:0];
   assign box_active = !culled && (l_c < r_c) && (b_c < t_c);

endmodule

// ===== rtl/tbr_edge.sv =====
// Edge-function coverage test of one pixel against the stored triangle.
// Depends on tbr_pkg for the default coordinate width.
module tbr_edge
   import tbr_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic signed [COORD_BITS-1:0] x1,
   input  logic signed [COORD_BITS-1:0] y1,
   input  logic signed [COORD_BITS-1:0] x2,
   input  logic signed [COORD_BITS-1:0] y2,
   input  logic signed [COORD_BITS-1:0] x3,
   input  logic signed [COORD_BITS-1:0] y3,
   input  logic        [COORD_BITS-1:0] px,
   input  logic        [COORD_BITS-1:0] py,
   output logic                         covered
);

   localparam int DW = COORD_BITS + 1;
   localparam int PW = 2 * COORD_BITS + 2;
   localparam int EW = 2 * COORD_BITS + 4;

   logic signed [DW-1:0] dx13, dy13, dx23, dy23, dx32, dy31, dpx, dpy;
   logic signed [PW-1:0] pd0, pd1, pe10, pe11, pe20, pe21;
   logic signed [EW-1:0] det, e1, e2, e3;
   logic                 ok1, ok2, ok3;

   assign dx13 = DW'(x1) - DW'(x3);
   assign dy13 = DW'(y1) - DW'(y3);
   assign dx23 = DW'(x2) - DW'(x3);
   assign dy23 = DW'(y2) - DW'(y3);
   assign dx32 = DW'(x3) - DW'(x2);
   assign dy31 = DW'(y3) - DW'(y1);
   assign dpx  = $signed({1'b0, px}) - DW'(x3);
   assign dpy  = $signed({1'b0, py}) - DW'(y3);

   assign pd0  = dx13 * dy23;
   assign pd1  = dx23 * dy13;
   assign pe10 = dy23 * dpx;
   assign pe11 = dx32 * dpy;
   assign pe20 = dy31 * dpx;
   assign pe21 = dx13 * dpy;

   assign det = EW'(pd0) - EW'(pd1);
   assign e1  = EW'(pe10) + EW'(pe11);
   assign e2  = EW'(pe20) + EW'(pe21);
   assign e3  = det - e1 - e2;

   assign ok1 = (e1 == '0) || (e1[EW-1] == det[EW-1]);
   assign ok2 = (e2 == '0) || (e2[EW-1] == det[EW-1]);
   assign ok3 = (e3 == '0) || (e3[EW-1] == det[EW-1]);

   assign covered = ok1 && ok2 && ok3;

endmodule

// ===== rtl/triangle_bbox_rasterizer.sv =====
// Top level of the triangle bounding-box rasterizer: scan state and result register.
// Depends on tbr_pkg, tbr_csr, tbr_bbox and tbr_edge.
//
//   Port group   Direction   Transfer condition
//   req_*        in          req_valid && req_ready
//   rsp_*        out         rsp_valid && rsp_ready
//   csr_*        in/out      csr_psel && csr_penable && csr_pwrite (write)
//
// Every request yields one response in the cycle after its transfer; one request
// is taken per cycle when no response stalls. The path from the scan registers
// through the edge-function multipliers into the response register sets cycle time.
// Reset clears the scan and response valid state and loads the register defaults.
// A stalled response only holds off the next request; req_ready stays high
// whenever the response register is empty or is being drained.
module triangle_bbox_rasterizer
   import tbr_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_op,
   input  logic signed [COORD_BITS-1:0] req_ax,
   input  logic signed [COORD_BITS-1:0] req_ay,
   input  logic signed [COORD_BITS-1:0] req_bx,
   input  logic signed [COORD_BITS-1:0] req_by,
   input  logic signed [COORD_BITS-1:0] req_cx,
   input  logic signed [COORD_BITS-1:0] req_cy,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic        [PIX_W-1:0]      rsp_pixel_x,
   output logic        [PIX_W-1:0]      rsp_pixel_y,
   output logic                         rsp_covered,
   output logic        [COLOR_W-1:0]    rsp_pixel_value,
   output logic                         rsp_box_empty,
   output logic                         rsp_last,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic        [ADDR_W-1:0]     csr_paddr,
   input  logic        [DATA_W-1:0]     csr_pwdata,
   output logic        [DATA_W-1:0]     csr_prdata,
   output logic                         csr_pready
);

   csr_regs_type regs;

   logic signed [COORD_BITS-1:0] vert_ff [6];
   logic        [COORD_BITS-1:0] left_ff, right_ff, bottom_ff, top_ff;
   logic        [COORD_BITS-1:0] scan_x_ff, scan_y_ff;
   logic                         active_ff;
   logic        [COORD_BITS-1:0] scan_x_in, scan_y_in;
   logic                         active_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic        [PIX_W-1:0]      pixel_x_ff, pixel_x_in;
   logic        [PIX_W-1:0]      pixel_y_ff, pixel_y_in;
   logic                         covered_ff, covered_in;
   logic        [COLOR_W-1:0]    pixel_value_ff, pixel_value_in;
   logic                         box_empty_ff, box_empty_in;
   logic                         last_ff, last_in;

   logic        [COORD_BITS-1:0] new_left, new_right, new_bottom, new_top;
   logic                         new_active;
   logic                         pix_covered;
   logic        [COORD_BITS:0]   x_inc, y_inc;
   logic                         x_wrap, y_done;
   logic        [PIX_W+COORD_BITS-1:0] x_ext, y_ext;
   logic                         accept;

   tbr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .regs        (regs)
   );

   tbr_bbox #(.COORD_BITS(COORD_BITS)) u_bbox (
      .ax           (req_ax),
      .ay           (req_ay),
      .bx           (req_bx),
      .by           (req_by),
      .cx           (req_cx),
      .cy           (req_cy),
      .image_width  (regs.image_width),
      .image_height (regs.image_height),
      .left         (new_left),
      .right        (new_right),
      .bottom       (new_bottom),
      .top          (new_top),
      .box_active   (new_active)
   );

   tbr_edge #(.COORD_BITS(COORD_BITS)) u_edge (
      .x1      (vert_ff[0]),
      .y1      (vert_ff[1]),
      .x2      (vert_ff[2]),
      .y2      (vert_ff[3]),
      .x3      (vert_ff[4]),
      .y3      (vert_ff[5]),
      .px      (scan_x_ff),
      .py      (scan_y_ff),
      .covered (pix_covered)
   );

   assign csr_pready = 1'b1;
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign accept     = req_valid && req_ready;

   assign x_inc  = {1'b0, scan_x_ff} + 1'b1;
   assign y_inc  = {1'b0, scan_y_ff} + 1'b1;
   assign x_wrap = x_inc >= {1'b0, right_ff};
   assign y_done = y_inc >= {1'b0, top_ff};
   assign x_ext  = {{PIX_W{1'b0}}, scan_x_ff};
   assign y_ext  = {{PIX_W{1'b0}}, scan_y_ff};

   always_comb begin
      scan_x_in      = scan_x_ff;
      scan_y_in      = scan_y_ff;
      active_in      = active_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      pixel_x_in     = pixel_x_ff;
      pixel_y_in     = pixel_y_ff;
      covered_in     = covered_ff;
      pixel_value_in = pixel_value_ff;
      box_empty_in   = box_empty_ff;
      last_in        = last_ff;
      if (accept) begin
         rsp_valid_in   = 1'b1;
         pixel_x_in     = '0;
         pixel_y_in     = '0;
         covered_in     = 1'b0;
         pixel_value_in = '0;
         box_empty_in   = 1'b0;
         last_in        = 1'b0;
         if (req_op == OP_START) begin
            scan_x_in    = new_left;
            scan_y_in    = new_bottom;
            active_in    = new_active;
            box_empty_in = !new_active;
            last_in      = !new_active;
         end else if (!active_ff) begin
            last_in = 1'b1;
         end else begin
            pixel_x_in     = x_ext[PIX_W-1:0];
            pixel_y_in     = y_ext[PIX_W-1:0];
            covered_in     = pix_covered;
            pixel_value_in = regs.pixel_color;
            if (x_wrap) begin
               scan_x_in = left_ff;
               scan_y_in = y_inc[COORD_BITS-1:0];
               if (y_done) begin
                  active_in = 1'b0;
                  last_in   = 1'b1;
               end
            end else begin
               scan_x_in = x_inc[COORD_BITS-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_x_ff      <= scan_x_in;
      scan_y_ff      <= scan_y_in;
      pixel_x_ff     <= pixel_x_in;
      pixel_y_ff     <= pixel_y_in;
      covered_ff     <= covered_in;
      pixel_value_ff <= pixel_value_in;
      box_empty_ff   <= box_empty_in;
      last_ff        <= last_in;
      if (accept && req_op == OP_START) begin
         vert_ff[0] <= req_ax;
         vert_ff[1] <= req_ay;
         vert_ff[2] <= req_bx;
         vert_ff[3] <= req_by;
         vert_ff[4] <= req_cx;
         vert_ff[5] <= req_cy;
         left_ff    <= new_left;
         right_ff   <= new_right;
         bottom_ff  <= new_bottom;
         top_ff     <= new_top;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_x     = pixel_x_ff;
   assign rsp_pixel_y     = pixel_y_ff;
   assign rsp_covered     = covered_ff;
   assign rsp_pixel_value = pixel_value_ff;
   assign rsp_box_empty   = box_empty_ff;
   assign rsp_last        = last_ff;

   a_scan_in_box: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (scan_x_ff >= left_ff) && (scan_x_ff < right_ff) &&
                    (scan_y_ff >= bottom_ff) && (scan_y_ff < top_ff))
      else $error("Scan position is outside the active box.");

   a_idle_advance: assert property (@(posedge clock) disable iff (reset)
      (accept && req_op == OP_ADVANCE && !active_ff) |=>
         (rsp_valid && rsp_last && !rsp_covered && rsp_pixel_value == '0))
      else $error("Advance with no box loaded gave a wrong response.");

   a_start_rsp: assert property (@(posedge clock) disable iff (reset)
      (accept && req_op == OP_START) |=>
         (rsp_valid && (rsp_last == rsp_box_empty) && !rsp_covered &&
          (rsp_box_empty == !active_ff)))
      else $error("Start response does not match the loaded box.");

endmodule
